FILE: hdl/c3nf_pkg.sv
package c3nf_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int COEF_W = 16;
	localparam int CH_W = 8;
	localparam int PIX_W = 24;
	localparam int PROD_W = 25;
	localparam int ROW_W = 27;
	localparam int ACC_W = 29;
	localparam int MAG_W = 27;
	localparam int DIV_BITS = 3;
	localparam int DIV_ST = MAG_W / DIV_BITS;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 48;
	localparam int WIDTH_REG_W = 12;
	localparam int HEIGHT_REG_W = 16;
	localparam int X_W = 11;
	localparam int Y_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KTOP   = 3'd0,
		REG_KMID   = 3'd1,
		REG_KBOT   = 3'd2,
		REG_WIDTH  = 3'd3,
		REG_HEIGHT = 3'd4
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic [COEF_W-1:0] rem;
		logic [MAG_W-1:0]  dq;
	} div_t;

	typedef struct packed {
		logic [X_W-1:0] cx;
		logic [Y_W-1:0] cy;
		logic           err;
	} meta_t;

	// Restoring division, several quotient bits per call; the quotient shifts into dq.
	function automatic div_t div_step(input div_t cur, input logic [COEF_W-1:0] d);
		div_t            res;
		logic [COEF_W:0] t;
		res = cur;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {res.rem, res.dq[MAG_W-1]};
			res.dq = {res.dq[MAG_W-2:0], 1'b0};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				res.dq[0] = 1'b1;
			end
			res.rem = t[COEF_W-1:0];
		end
		return res;
	endfunction

endpackage

FILE: hdl/c3nf_cfg_if.sv
interface c3nf_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [c3nf_pkg::CFG_IDX_W-1:0]  index;
	logic [c3nf_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/c3nf_pix_in_if.sv
interface c3nf_pix_in_if;
	logic                      valid;
	logic                      ready;
	logic                      frame_start;
	logic [c3nf_pkg::CH_W-1:0] blue_in;
	logic [c3nf_pkg::CH_W-1:0] green_in;
	logic [c3nf_pkg::CH_W-1:0] red_in;
	modport source (output valid, output frame_start, output blue_in, output green_in,
		output red_in, input ready);
	modport sink (input valid, input frame_start, input blue_in, input green_in,
		input red_in, output ready);
endinterface

FILE: hdl/c3nf_pix_out_if.sv
interface c3nf_pix_out_if;
	logic                      valid;
	logic                      ready;
	logic [c3nf_pkg::X_W-1:0]  center_x;
	logic [c3nf_pkg::Y_W-1:0]  center_y;
	logic [c3nf_pkg::CH_W-1:0] blue_out;
	logic [c3nf_pkg::CH_W-1:0] green_out;
	logic [c3nf_pkg::CH_W-1:0] red_out;
	logic                      zero_sum_error;
	modport source (output valid, output center_x, output center_y, output blue_out,
		output green_out, output red_out, output zero_sum_error, input ready);
	modport sink (input valid, input center_x, input center_y, input blue_out,
		input green_out, input red_out, input zero_sum_error, output ready);
endinterface

FILE: hdl/conv3x3_normalized_rgb_filter_core.sv
// A pixel word passes the line store read, window, product, row sum, channel sum, divider and output registers.
// Throughput: one pixel word per cycle; the whole pipeline holds when the output word waits.
// The line stores are one 48-bit memory with a registered read and a write in the cycle after the read.
// The divider takes three quotient bits per stage over nine stages.
// Reset loads the configuration defaults and clears the position counters, the window and all valid bits;
// the line stores are not cleared.
module conv3x3_normalized_rgb_filter_core #(
	parameter int MAX_WIDTH = c3nf_pkg::MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	c3nf_cfg_if.sink          cfg,
	c3nf_pix_in_if.sink       pixel_in,
	c3nf_pix_out_if.source    pixel_out
);

	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW = (CW + 1 > c3nf_pkg::WIDTH_REG_W) ? CW + 1 : c3nf_pkg::WIDTH_REG_W;
	localparam int HW = c3nf_pkg::HEIGHT_REG_W;
	localparam int CHW = c3nf_pkg::CH_W;
	localparam int KW = c3nf_pkg::COEF_W;
	localparam int DS = c3nf_pkg::DIV_ST;

	logic [c3nf_pkg::CFG_DATA_W-1:0] kern_q [3];
	logic [c3nf_pkg::WIDTH_REG_W-1:0] width_q;
	logic [HW-1:0] height_q;

	logic [CW-1:0] col_q;
	logic [HW-1:0] row_q;

	logic adv, acc;
	logic out_valid_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_q[0] <= '0;
			kern_q[1] <= 48'h0000_0001_0000;
			kern_q[2] <= '0;
			width_q   <= 12'd640;
			height_q  <= 16'd480;
		end else if (cfg.valid) begin
			unique case (c3nf_pkg::cfg_reg_t'(cfg.index))
				c3nf_pkg::REG_KTOP:   kern_q[0] <= cfg.data;
				c3nf_pkg::REG_KMID:   kern_q[1] <= cfg.data;
				c3nf_pkg::REG_KBOT:   kern_q[2] <= cfg.data;
				c3nf_pkg::REG_WIDTH:  width_q <= cfg.data[c3nf_pkg::WIDTH_REG_W-1:0];
				c3nf_pkg::REG_HEIGHT: height_q <= cfg.data[HW-1:0];
				default: ;
			endcase
		end
	end

	// Kernel sum and its magnitude, refreshed every cycle from the registers.
	logic [KW-1:0] ksum_c, ksum_q, dabs_q;

	always_comb begin
		ksum_c = '0;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				ksum_c = ksum_c + kern_q[r][KW*c +: KW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksum_q <= '0;
			dabs_q <= '0;
		end else begin
			ksum_q <= ksum_c;
			dabs_q <= ksum_c[KW-1] ? KW'(-ksum_c) : ksum_c;
		end
	end

	// Position of the incoming pixel and of the one after it.
	logic [EW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [CW-1:0] x_c, nx_c;
	logic [HW:0]   yw_c, ny_c;
	logic [HW-1:0] y_c;
	logic [EW-1:0] nxe_c;
	logic [HW-1:0] nrow_c;

	always_comb begin
		w_eff = EW'(width_q);
		if (w_eff < EW'(3))
			w_eff = EW'(3);
		if (w_eff > EW'(MAX_WIDTH))
			w_eff = EW'(MAX_WIDTH);
		h_eff = (height_q < HW'(3)) ? HW'(3) : height_q;

		x_c  = pixel_in.frame_start ? '0 : col_q;
		yw_c = pixel_in.frame_start ? '0 : {1'b0, row_q};
		if (EW'(x_c) >= w_eff) begin
			x_c  = '0;
			yw_c = yw_c + 1'b1;
		end
		if (yw_c >= {1'b0, h_eff})
			yw_c = '0;
		y_c = yw_c[HW-1:0];

		nxe_c  = EW'(x_c) + 1'b1;
		nx_c   = nxe_c[CW-1:0];
		nrow_c = y_c;
		if (nxe_c >= w_eff) begin
			nx_c = '0;
			ny_c = {1'b0, y_c} + 1'b1;
			nrow_c = (ny_c >= {1'b0, h_eff}) ? '0 : ny_c[HW-1:0];
		end else begin
			ny_c = {1'b0, y_c};
		end
	end

	assign adv = !out_valid_q || pixel_out.ready;
	assign pixel_in.ready = adv;
	assign acc = pixel_in.valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			col_q <= nx_c;
			row_q <= nrow_c;
		end
	end

	// Stage 1: line store read; the entry is rewritten in the following cycle.
	logic [2*c3nf_pkg::PIX_W-1:0] lmem [MAX_WIDTH];
	logic [2*c3nf_pkg::PIX_W-1:0] rd_q;
	logic          wr_pend_q;
	logic          v_s1;
	logic [CW-1:0] x_s1;
	logic [HW-1:0] y_s1;
	c3nf_pkg::pix_t pix_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			if (wr_pend_q && x_c == x_s1)
				rd_q <= {rd_q[c3nf_pkg::PIX_W-1:0], pix_s1};
			else
				rd_q <= lmem[x_c];
		end
		if (wr_pend_q)
			lmem[x_s1] <= {rd_q[c3nf_pkg::PIX_W-1:0], pix_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_q <= 1'b0;
			v_s1      <= 1'b0;
		end else begin
			wr_pend_q <= acc;
			if (adv)
				v_s1 <= pixel_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1   <= x_c;
			y_s1   <= y_c;
			pix_s1 <= {pixel_in.red_in, pixel_in.green_in, pixel_in.blue_in};
		end
	end

	// Stage 2: window shift.
	c3nf_pkg::pix_t win_q [3][3];
	logic v_s2;
	c3nf_pkg::meta_t meta_s2;
	logic [31:0] cx32;

	assign cx32 = 32'(x_s1) - 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			for (int c = 0; c < 3; c++)
				for (int r = 0; r < 3; r++)
					win_q[c][r] <= '0;
		end else if (adv) begin
			v_s2 <= v_s1 && (x_s1 >= CW'(2)) && (y_s1 >= HW'(2));
			if (v_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[0][r] <= win_q[1][r];
					win_q[1][r] <= win_q[2][r];
				end
				win_q[2][0] <= rd_q[2*c3nf_pkg::PIX_W-1:c3nf_pkg::PIX_W];
				win_q[2][1] <= rd_q[c3nf_pkg::PIX_W-1:0];
				win_q[2][2] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2.cx  <= cx32[c3nf_pkg::X_W-1:0];
			meta_s2.cy  <= y_s1 - 1'b1;
			meta_s2.err <= (ksum_q == '0);
		end
	end

	// Stage 3: products.
	logic v_s3;
	c3nf_pkg::meta_t meta_s3;
	logic signed [c3nf_pkg::PROD_W-1:0] prod_s3 [3][3][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s3 <= meta_s2;
			for (int ch = 0; ch < 3; ch++)
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++)
						prod_s3[ch][r][c] <= $signed(kern_q[r][KW*c +: KW]) *
							$signed({1'b0, win_q[c][r][CHW*ch +: CHW]});
		end
	end

	// Stage 4: row sums.
	logic v_s4;
	c3nf_pkg::meta_t meta_s4;
	logic signed [c3nf_pkg::ROW_W-1:0] row_s4 [3][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s4 <= meta_s3;
			for (int ch = 0; ch < 3; ch++)
				for (int r = 0; r < 3; r++)
					row_s4[ch][r] <= c3nf_pkg::ROW_W'(prod_s3[ch][r][0]) +
						c3nf_pkg::ROW_W'(prod_s3[ch][r][1]) +
						c3nf_pkg::ROW_W'(prod_s3[ch][r][2]);
		end
	end

	// Stage 5: channel sums.
	logic v_s5;
	c3nf_pkg::meta_t meta_s5;
	logic signed [c3nf_pkg::ACC_W-1:0] acc_s5 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s5 <= meta_s4;
			for (int ch = 0; ch < 3; ch++)
				acc_s5[ch] <= c3nf_pkg::ACC_W'(row_s4[ch][0]) +
					c3nf_pkg::ACC_W'(row_s4[ch][1]) + c3nf_pkg::ACC_W'(row_s4[ch][2]);
		end
	end

	// Stage 6: magnitude and quotient sign, then the divider stages.
	logic signed [c3nf_pkg::ACC_W-1:0] nacc [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++)
			nacc[ch] = -acc_s5[ch];
	end

	c3nf_pkg::div_t  dv_sd [DS+1][3];
	c3nf_pkg::div_t  dn_c [DS][3];
	c3nf_pkg::meta_t meta_sd [DS+1];
	logic [2:0]      neg_sd [DS+1];
	logic [DS:0]     v_sd;

	always_comb begin
		for (int s = 0; s < DS; s++)
			for (int ch = 0; ch < 3; ch++)
				dn_c[s][ch] = c3nf_pkg::div_step(dv_sd[s][ch], dabs_q);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_sd[0] <= meta_s5;
			for (int ch = 0; ch < 3; ch++) begin
				neg_sd[0][ch]    <= acc_s5[ch][c3nf_pkg::ACC_W-1] ^ ksum_q[KW-1];
				dv_sd[0][ch].rem <= '0;
				dv_sd[0][ch].dq  <= acc_s5[ch][c3nf_pkg::ACC_W-1] ?
					nacc[ch][c3nf_pkg::MAG_W-1:0] : acc_s5[ch][c3nf_pkg::MAG_W-1:0];
			end
			for (int s = 0; s < DS; s++) begin
				meta_sd[s+1] <= meta_sd[s];
				neg_sd[s+1]  <= neg_sd[s];
				for (int ch = 0; ch < 3; ch++)
					dv_sd[s+1][ch] <= dn_c[s][ch];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_sd <= '0;
		end else if (adv) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_sd <= {v_sd[DS-1:0], v_s5};
		end
	end

	// Output register.
	c3nf_pkg::meta_t  meta_q;
	logic [CHW-1:0]   chan_q [3];
	logic [c3nf_pkg::MAG_W-1:0] qt [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++)
			qt[ch] = neg_sd[DS][ch] ? c3nf_pkg::MAG_W'(-dv_sd[DS][ch].dq) : dv_sd[DS][ch].dq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= v_sd[DS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_q <= meta_sd[DS];
			for (int ch = 0; ch < 3; ch++)
				chan_q[ch] <= meta_sd[DS].err ? '0 : qt[ch][CHW-1:0];
		end
	end

	assign pixel_out.valid          = out_valid_q;
	assign pixel_out.center_x       = meta_q.cx;
	assign pixel_out.center_y       = meta_q.cy;
	assign pixel_out.blue_out       = chan_q[0];
	assign pixel_out.green_out      = chan_q[1];
	assign pixel_out.red_out        = chan_q[2];
	assign pixel_out.zero_sum_error = meta_q.err;

endmodule
